### design/rpn_pkg.sv
// rpn_pkg: types and codes shared by the rpn stack evaluator modules
// no dependencies
package rpn_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 6;

  typedef enum logic [4:0] {
    FN_LIT  = 5'd0,  FN_VAR  = 5'd1,  FN_ADD  = 5'd2,  FN_SUB  = 5'd3,
    FN_MUL  = 5'd4,  FN_DIV  = 5'd5,  FN_MOD  = 5'd6,  FN_SHL  = 5'd7,
    FN_SHR  = 5'd8,  FN_LT   = 5'd9,  FN_GT   = 5'd10, FN_LE   = 5'd11,
    FN_GE   = 5'd12, FN_EQ   = 5'd13, FN_NE   = 5'd14, FN_ASG  = 5'd15,
    FN_CADD = 5'd16, FN_CSUB = 5'd17, FN_CMUL = 5'd18, FN_CDIV = 5'd19,
    FN_CMOD = 5'd20, FN_CSHL = 5'd21, FN_CSHR = 5'd22, FN_LOAD = 5'd23
  } func_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_UNDER = 3'd1, ST_OVER = 3'd2, ST_DIV0 = 3'd3, ST_LITASSIGN = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_EXEC, S_DIV, S_WRITE, S_FINAL, S_OUT
  } state_e;

  typedef struct packed {
    logic [4:0]        func;
    logic signed [31:0] literal_value;
    logic [5:0]        var_index;
    logic              last_token;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         status;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch incoming word
    logic fetch;     // read stack operands and variable store
    logic exec;      // decide and perform token
    logic div_start;
    logic write;     // finish binary op
    logic final_rd;  // resolve bottom entry value
    logic emit;      // load output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic is_last;
    logic binop_ok;
  } dp_stat_t;

endpackage

### design/rpn_ctrl.sv
// rpn_ctrl: sequencing state machine of the evaluator
// depends on rpn_pkg
module rpn_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             obuf_full_i,
  input  rpn_pkg::dp_stat_t stat_i,
  output rpn_pkg::dp_cmd_t  cmd_o
);
  import rpn_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else if (stat_i.binop_ok) state_d = S_WRITE;
        else if (stat_i.is_last) state_d = S_FINAL;
        else state_d = S_IDLE;
      end
      S_DIV: if (stat_i.div_done) state_d = S_WRITE;
      S_WRITE: begin
        cmd_o.write = 1'b1;
        state_d = stat_i.is_last ? S_FINAL : S_IDLE;
      end
      S_FINAL: begin
        cmd_o.final_rd = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!obuf_full_i) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

### design/rpn_div.sv
// rpn_div: iterative signed divider, one quotient bit per cycle
// depends on rpn_pkg
module rpn_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic [31:0] rem_o
);
  import rpn_pkg::*;

  logic [31:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] div_q;
  logic        nq_q, nr_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [32:0] trial;

  assign trial = {rem_q[31:0], quo_q[31]} - {1'b0, div_q};

  always_comb begin
    quo_d = {quo_q[30:0], ~trial[32]};
    rem_d = trial[32] ? {rem_q[31:0], quo_q[31]} : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'd32;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= a_i[31] ? (32'd0 - a_i) : a_i;
      div_q <= b_i[31] ? (32'd0 - b_i) : b_i;
      rem_q <= '0;
      nq_q  <= a_i[31] ^ b_i[31];
      nr_q  <= a_i[31];
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = busy_q && (cnt_q == 6'd0) ? 1'b0 : (!busy_q && cnt_q == 6'd0);
  assign quo_o  = nq_q ? (32'd0 - quo_q) : quo_q;
  assign rem_o  = nr_q ? (32'd0 - rem_q[31:0]) : rem_q[31:0];
endmodule

### design/rpn_dp.sv
// rpn_dp: operand stack, variable store, alu and output register
// depends on rpn_pkg and rpn_div
module rpn_dp #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned NUM_VARS    = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rpn_pkg::in_word_t  in_word_i,
  input  rpn_pkg::dp_cmd_t   cmd_i,
  output rpn_pkg::dp_stat_t  stat_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output rpn_pkg::out_word_t out_word_o
);
  import rpn_pkg::*;

  localparam int unsigned SpW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SaW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned VaW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

  // stack memory: tag + 32 bits, three read ports
  logic [32:0]    stk_mem [STACK_DEPTH];
  logic [32:0]    top_q, deep_q;
  logic [SpW-1:0] sp_q;
  logic [2:0]     err_q;
  in_word_t       w_q;

  // variable store with valid bits, values read in registered form
  logic [31:0]         var_mem [NUM_VARS];
  logic [NUM_VARS-1:0] var_vld_q;
  logic [31:0]         va_q, vb_q;
  logic [31:0]         res_q;
  logic                div_busy_q;

  logic [SpW-1:0] sp_m1, sp_m2;
  assign sp_m1 = sp_q - SpW'(1);
  assign sp_m2 = sp_q - SpW'(2);

  // fetch stage: read stack entries and variable store
  logic [32:0] top_e, deep_e;
  assign top_e  = stk_mem[sp_m1[SaW-1:0]];
  assign deep_e = stk_mem[sp_m2[SaW-1:0]];
  logic [32:0] bot_e;
  assign bot_e = stk_mem[0];

  logic oka, okb;
  assign oka = deep_e[31:0] < 32'(NUM_VARS);
  assign okb = top_e[31:0] < 32'(NUM_VARS);

  logic a_ok_q, b_ok_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      top_q  <= top_e;
      deep_q <= deep_e;
      va_q   <= var_mem[VaW'(deep_e[31:0])];
      vb_q   <= var_mem[VaW'(top_e[31:0])];
      a_ok_q <= oka && var_vld_q[VaW'(deep_e[31:0])];
      b_ok_q <= okb && var_vld_q[VaW'(top_e[31:0])];
    end
    if (cmd_i.final_rd) begin
      va_q   <= var_mem[VaW'(bot_e[31:0])];
      a_ok_q <= (bot_e[31:0] < 32'(NUM_VARS)) && var_vld_q[VaW'(bot_e[31:0])];
      deep_q <= bot_e;
    end
  end

  // operand values
  logic [31:0] a, b;
  assign a = deep_q[32] ? (a_ok_q ? va_q : 32'd0) : deep_q[31:0];
  assign b = top_q[32]  ? (b_ok_q ? vb_q : 32'd0) : top_q[31:0];

  // compound codes map back onto the plain operator codes
  func_e aop;
  always_comb begin
    if (w_q.func >= FN_CADD && w_q.func <= FN_CSHR) aop = func_e'(w_q.func - 5'd14);
    else aop = func_e'(w_q.func);
  end

  logic [31:0] alu_r;
  logic [63:0] prod;
  assign prod = a * b;
  always_comb begin
    case (aop)
      FN_ADD: alu_r = a + b;
      FN_SUB: alu_r = a - b;
      FN_MUL: alu_r = prod[31:0];
      FN_SHL: alu_r = a << b[4:0];
      FN_SHR: alu_r = 32'($signed(a) >>> b[4:0]);
      FN_LT:  alu_r = {31'd0, $signed(a) <  $signed(b)};
      FN_GT:  alu_r = {31'd0, $signed(a) >  $signed(b)};
      FN_LE:  alu_r = {31'd0, $signed(a) <= $signed(b)};
      FN_GE:  alu_r = {31'd0, $signed(a) >= $signed(b)};
      FN_EQ:  alu_r = {31'd0, a == b};
      FN_NE:  alu_r = {31'd0, a != b};
      default: alu_r = 32'd0;
    endcase
  end

  logic        is_bin, is_asg, is_divop, div_done;
  logic [31:0] quo, rem;
  assign is_bin   = w_q.func >= FN_ADD && w_q.func <= FN_CSHR;
  assign is_asg   = w_q.func >= FN_ASG && w_q.func <= FN_CSHR;
  assign is_divop = aop == FN_DIV || aop == FN_MOD;

  logic exec_ok;
  assign exec_ok = err_q == ST_OK && is_bin && sp_q >= SpW'(2) && !(is_asg && !deep_q[32])
                   && !(is_divop && b == 32'd0);

  rpn_div u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_start), .a_i(a), .b_i(b),
    .done_o(div_done), .quo_o(quo), .rem_o(rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div_busy_q <= 1'b0;
    else if (cmd_i.div_start) div_busy_q <= 1'b1;
    else if (cmd_i.write) div_busy_q <= 1'b0;
  end

  assign stat_o.need_div = cmd_i.exec && exec_ok && is_divop;
  assign stat_o.div_done = div_done && div_busy_q && !cmd_i.div_start;
  assign stat_o.is_last  = w_q.last_token;
  assign stat_o.binop_ok = exec_ok;

  logic [31:0] r_fin;
  always_comb begin
    if (w_q.func == FN_ASG) r_fin = b;
    else if (is_divop) r_fin = (aop == FN_DIV) ? quo : rem;
    else r_fin = res_q;
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q      <= '0;
      err_q     <= ST_OK;
      var_vld_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.emit) out_valid_o <= 1'b1;
      else if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      if (cmd_i.exec) begin
        if (w_q.func == FN_LOAD) begin
          if (32'(w_q.var_index) < 32'(NUM_VARS)) var_vld_q[VaW'(w_q.var_index)] <= 1'b1;
        end else if (err_q == ST_OK) begin
          if (w_q.func == FN_LIT || w_q.func == FN_VAR) begin
            if (sp_q >= SpW'(STACK_DEPTH)) err_q <= ST_OVER;
            else sp_q <= sp_q + SpW'(1);
          end else if (is_bin) begin
            if (sp_q < SpW'(2)) err_q <= ST_UNDER;
            else if (is_asg && !deep_q[32]) err_q <= ST_LITASSIGN;
            else if (is_divop && b == 32'd0) err_q <= ST_DIV0;
          end
        end
      end
      if (cmd_i.write) begin
        sp_q <= sp_m1;
        if (is_asg && deep_q[31:0] < 32'(NUM_VARS)) var_vld_q[VaW'(deep_q[31:0])] <= 1'b1;
      end
      if (cmd_i.emit) begin
        sp_q  <= '0;
        err_q <= ST_OK;
      end
    end
  end

  // payload registers and memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) w_q <= in_word_i;
    if (cmd_i.exec) res_q <= alu_r;
    if (cmd_i.exec && w_q.func == FN_LOAD && 32'(w_q.var_index) < 32'(NUM_VARS))
      var_mem[VaW'(w_q.var_index)] <= w_q.literal_value;
    if (cmd_i.exec && w_q.func != FN_LOAD && err_q == ST_OK && sp_q < SpW'(STACK_DEPTH)) begin
      if (w_q.func == FN_LIT) stk_mem[sp_q[SaW-1:0]] <= {1'b0, w_q.literal_value};
      if (w_q.func == FN_VAR) stk_mem[sp_q[SaW-1:0]] <= {1'b1, 26'd0, w_q.var_index};
    end
    if (cmd_i.write) begin
      stk_mem[sp_m2[SaW-1:0]] <= {1'b0,
        (is_asg && deep_q[31:0] >= 32'(NUM_VARS)) ? 32'd0 : r_fin};
      if (is_asg && deep_q[31:0] < 32'(NUM_VARS)) var_mem[VaW'(deep_q[31:0])] <= r_fin;
    end
    if (cmd_i.emit) begin
      out_word_o.status       <= (err_q == ST_OK && sp_q == '0) ? ST_UNDER : err_q;
      out_word_o.result_value <= (err_q == ST_OK && sp_q != '0) ? a : 32'd0;
    end
  end
endmodule

### design/rpn_stack_evaluator.sv
// rpn_stack_evaluator: top level of the postfix expression evaluator
// depends on rpn_pkg, rpn_ctrl, rpn_dp
//
// usage
//   in channel: one token word per handshake (in_valid_i / in_stall_o),
//   taken when valid is high and stall is low
//   out channel: one result word per expression, raised after the word
//   with last_token set (out_valid_o / out_stall_i)
// steps
//   push, load and rejected tokens: capture, fetch and execute
//   binary operators: a write step follows; div and mod wait in the
//   radix-2 divider between execute and write, which sets the worst case
//   last token adds a final step to resolve the bottom entry and an
//   output step to load the output register
// stall
//   a stalled result holds in the output register; the next result
//   waits until that one is taken, earlier tokens keep flowing
// reset
//   stack empty, error clear, all variables read as zero
module rpn_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned NUM_VARS    = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rpn_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rpn_pkg::out_word_t out_word_o
);
  import rpn_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     obuf_full;

  // output register still occupied and not leaving this cycle
  assign obuf_full = out_valid_o && out_stall_i;

  rpn_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .obuf_full_i(obuf_full), .stat_i(stat), .cmd_o(cmd)
  );

  rpn_dp #(.STACK_DEPTH(STACK_DEPTH), .NUM_VARS(NUM_VARS)) u_dp (
    .clk_i, .rst_ni, .in_word_i, .cmd_i(cmd), .stat_o(stat),
    .out_stall_i, .out_valid_o, .out_word_o
  );

  // loading the output register raises out_valid_o
  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_valid_o) else $error("emit lost");

  // never accept a word while a token is in flight
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> in_stall_o) else $error("overlapping tokens");

  // divider start only from a checked binary operation
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> cmd.exec && stat.binop_ok) else $error("bad divider start");
endmodule

### tb/rpn_stack_evaluator_test.sv
// rpn_stack_evaluator_test: self-checking bench for the postfix expression evaluator
// drives token words, predicts each expression result, checks every result word
// depends on rpn_pkg and rpn_stack_evaluator
`timescale 1ns / 1ps

module rpn_stack_evaluator_test;
  import rpn_pkg::*;

  localparam int unsigned Depth   = 16;
  localparam int unsigned NumVars = 64;
  localparam longint      CycleLimit = 2_000_000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  rpn_stack_evaluator #(
    .STACK_DEPTH(Depth),
    .NUM_VARS   (NumVars)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  // clock, 10 ns period
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // idle percentages, changed per phase
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off;      // long receiver stall requested
  bit          hold_done;     // long stall already served
  int unsigned err_count;
  longint      cycle_count;

  // predictor state
  bit          stk_var[Depth];
  logic [31:0] stk_val[Depth];
  int unsigned sp;
  logic [31:0] vars[NumVars];
  status_e     err;

  out_word_t   expected_results[$];

  function automatic logic [31:0] var_read(logic [31:0] idx);
    return (idx < NumVars) ? vars[idx] : 32'd0;
  endfunction

  function automatic logic [31:0] entry_val(int unsigned pos);
    return stk_var[pos] ? var_read(stk_val[pos]) : stk_val[pos];
  endfunction

  // op in base code order: add sub mul div mod shl shr lt gt le ge eq ne
  function automatic logic [31:0] alu_eval(func_e op, logic [31:0] a, logic [31:0] b,
                                           output bit div0);
    logic signed [31:0] sa;
    logic signed [31:0] sb;
    sa = a;
    sb = b;
    div0 = 1'b0;
    case (op)
      FN_ADD: return a + b;
      FN_SUB: return a - b;
      FN_MUL: return a * b;
      FN_DIV: begin
        if (b == 0) begin
          div0 = 1'b1;
          return 32'd0;
        end
        // most negative over -1 wraps to itself
        if (a == 32'h8000_0000 && b == 32'hffff_ffff) return a;
        return sa / sb;
      end
      FN_MOD: begin
        if (b == 0) begin
          div0 = 1'b1;
          return 32'd0;
        end
        if (a == 32'h8000_0000 && b == 32'hffff_ffff) return 32'd0;
        return sa % sb;
      end
      FN_SHL: return a << b[4:0];
      FN_SHR: return sa >>> b[4:0];
      FN_LT:  return {31'd0, sa < sb};
      FN_GT:  return {31'd0, sa > sb};
      FN_LE:  return {31'd0, sa <= sb};
      FN_GE:  return {31'd0, sa >= sb};
      FN_EQ:  return {31'd0, a == b};
      default: return {31'd0, a != b};
    endcase
  endfunction

  function automatic void stack_push(bit is_var, logic [31:0] v);
    if (sp >= Depth) begin
      err = ST_OVER;
      return;
    end
    stk_var[sp] = is_var;
    stk_val[sp] = v;
    sp++;
  endfunction

  function automatic void apply_token(in_word_t w);
    int unsigned top;
    int unsigned deep;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    bit          div0;
    func_e       op;
    if (w.func == FN_LIT) begin
      stack_push(1'b0, w.literal_value);
      return;
    end
    if (w.func == FN_VAR) begin
      stack_push(1'b1, {26'd0, w.var_index});
      return;
    end
    if (w.func < FN_ADD || w.func > FN_CSHR) return;  // unused codes do nothing
    if (sp < 2) begin
      err = ST_UNDER;
      return;
    end
    top  = sp - 1;
    deep = sp - 2;
    // assignment needs a variable as the deeper operand, checked before div by zero
    if (w.func >= FN_ASG && !stk_var[deep]) begin
      err = ST_LITASSIGN;
      return;
    end
    a = entry_val(deep);
    b = entry_val(top);
    div0 = 1'b0;
    if (w.func == FN_ASG) r = b;
    else begin
      // compound codes map back onto the plain operator codes
      op = (w.func > FN_ASG) ? func_e'(w.func - 5'd14) : func_e'(w.func);
      r = alu_eval(op, a, b, div0);
    end
    if (div0) begin
      err = ST_DIV0;
      return;
    end
    sp -= 2;
    if (w.func >= FN_ASG) begin
      if (stk_val[deep] < NumVars) vars[stk_val[deep]] = r;
      r = var_read(stk_val[deep]);
    end
    stack_push(1'b0, r);
  endfunction

  // advance the predictor by one accepted word, queue the result if any
  function automatic void predict_word(in_word_t w);
    out_word_t res;
    if (w.func == FN_LOAD) vars[w.var_index] = w.literal_value;
    else if (err == ST_OK) apply_token(w);
    if (!w.last_token) return;
    res.result_value = '0;
    res.status       = err;
    if (err == ST_OK) begin
      if (sp == 0) res.status = ST_UNDER;
      else res.result_value = entry_val(0);
    end
    expected_results.insert(expected_results.size(), res);
    sp  = 0;
    err = ST_OK;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  // send one word, respecting sender idling; valid stays up until the next word or idle
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predict_word(w);
  endtask

  function automatic in_word_t make_word(func_e f, logic [31:0] lit, logic [5:0] idx,
                                         bit last);
    in_word_t w;
    w.func          = f;
    w.literal_value = lit;
    w.var_index     = idx;
    w.last_token    = last;
    return w;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result word", out_word.result_value, 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_word.status !== want.status)
          report_mismatch("status", out_word.status, want.status);
        if (out_word.result_value !== want.result_value)
          report_mismatch("result_value", out_word.result_value, want.result_value);
      end
    end
  end

  // receiver stall, with one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off && !hold_done) begin
      hold_done = 1'b1;
      out_stall <= 1'b1;
      repeat (400) @(posedge clk_i);
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("rpn_stack_evaluator_test: done, errors");
      $finish;
    end
  end

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(8);
      default: return $urandom;
    endcase
  endfunction

  // directed: field extremes, every operator, the special cases
  task automatic test_directed();
    func_e f;
    send_word(make_word(FN_LOAD, 32'h8000_0000, 6'd63, 1'b0));
    send_word(make_word(FN_VAR, 32'hffff_ffff, 6'd63, 1'b1));   // most negative var
    send_word(make_word(FN_LIT, 32'h7fff_ffff, 6'd0, 1'b1));    // largest literal
    send_word(make_word(FN_LIT, 32'd5, 6'd0, 1'b0));
    send_word(make_word(FN_ADD, 32'd0, 6'd0, 1'b1));            // underflow
    send_word(make_word(FN_NE, 32'd0, 6'd0, 1'b1));             // underflow on an empty stack
    send_word(make_word(func_e'(5'd31), 32'd0, 6'd0, 1'b1));    // unused code
    // most negative divided by -1
    send_word(make_word(FN_LIT, 32'h8000_0000, 6'd0, 1'b0));
    send_word(make_word(FN_LIT, 32'hffff_ffff, 6'd0, 1'b0));
    send_word(make_word(FN_DIV, 32'd0, 6'd0, 1'b1));
    send_word(make_word(FN_LIT, 32'h8000_0000, 6'd0, 1'b0));
    send_word(make_word(FN_LIT, 32'hffff_ffff, 6'd0, 1'b0));
    send_word(make_word(FN_MOD, 32'd0, 6'd0, 1'b1));
    // divide by zero, then error latched while load still acts
    send_word(make_word(FN_LIT, 32'd9, 6'd0, 1'b0));
    send_word(make_word(FN_LIT, 32'd0, 6'd0, 1'b0));
    send_word(make_word(FN_DIV, 32'd0, 6'd0, 1'b0));
    send_word(make_word(FN_LOAD, 32'd77, 6'd1, 1'b1));
    // assign to a literal
    send_word(make_word(FN_LIT, 32'd1, 6'd0, 1'b0));
    send_word(make_word(FN_LIT, 32'd2, 6'd0, 1'b0));
    send_word(make_word(FN_ASG, 32'd0, 6'd0, 1'b1));
    // overflow: one push past a full stack
    for (int i = 0; i <= Depth; i++) send_word(make_word(FN_LIT, 32'(i), 6'd0, i == Depth));
    // every binary operator on a variable and a literal
    for (int k = FN_ADD; k <= FN_CSHR; k++) begin
      f = func_e'(k);
      send_word(make_word(FN_VAR, 32'd0, 6'd1, 1'b0));
      send_word(make_word(FN_LIT, 32'hffff_fffd, 6'd0, 1'b0));
      send_word(make_word(f, 32'd0, 6'd0, 1'b1));
    end
  endtask

  // one random well-formed expression, sometimes broken
  task automatic send_expression(output int unsigned sent);
    int unsigned depth;
    int unsigned n;
    int unsigned k;
    in_word_t    w;
    depth = 0;
    n = $urandom_range(1, 12);
    for (int unsigned i = 0; i < n; i++) begin
      w.literal_value = rand_value();
      w.var_index     = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(7));
      w.last_token    = 1'b0;
      k = $urandom_range(99);
      if (k < 4) w.func = 5'($urandom);                        // noise, any code
      else if (k < 8) w.func = FN_LOAD;
      else if (depth < 2 || (k < 45 && depth < Depth)) begin
        w.func = ($urandom_range(1)) ? FN_LIT : FN_VAR;
        depth++;
      end else begin
        w.func = 5'($urandom_range(FN_ADD, FN_CSHR));
        depth--;
      end
      send_word(w);
    end
    w.func          = ($urandom_range(3) == 0) ? 5'($urandom) : FN_VAR;
    w.literal_value = $urandom;
    w.var_index     = 6'($urandom);
    w.last_token    = 1'b1;
    send_word(w);
    sent = n + 1;
  endtask

  task automatic test_random(int unsigned words);
    int unsigned total;
    int unsigned sent;
    total = 0;
    while (total < words) begin
      send_expression(sent);
      total += sent;
    end
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    int unsigned sent;
    hold_off <= 1'b1;
    repeat (40) send_expression(sent);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    in_word       = '0;
    out_stall     = 1'b0;
    hold_off      = 1'b0;
    err_count     = 0;
    cycle_count   = 0;
    sp            = 0;
    err           = ST_OK;
    send_idle_pct = 33;
    recv_idle_pct = 74;
    for (int i = 0; i < NumVars; i++) vars[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(400);
    send_idle_pct = 74;
    recv_idle_pct = 33;
    test_random(400);
    test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(350);
    in_valid <= 1'b0;
    wait_drained();

    if (err_count == 0) $display("rpn_stack_evaluator_test: done, clean");
    else $display("rpn_stack_evaluator_test: done, errors");
    $finish;
  end

endmodule
